// ===== rtl/core/xorshift128_ranged_random_top_defines.svh =====
// ----------------------------------------------------------------------------
// xorshift128_ranged_random_top_defines.svh
// Assertion macros for the ranged xorshift128 block. Empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef XORSHIFT128_RANGED_RANDOM_TOP_DEFINES_SVH
`define XORSHIFT128_RANGED_RANDOM_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge outside reset
`define XSR_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication
`define XSR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define XSR_ASSERT_IMPLY(lbl, ante, cons, msg)
`define XSR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/xsr_pkg.sv =====
// ----------------------------------------------------------------------------
// xsr_pkg
// Types and constants shared by the ranged xorshift128 generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xsr_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned DIV_STEPS = WORD_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [WORD_W-1:0] SEED_X = 32'd123456789;
   localparam logic [WORD_W-1:0] SEED_Y = 32'd362436069;
   localparam logic [WORD_W-1:0] SEED_Z = 32'd521288629;
   localparam logic [WORD_W-1:0] SEED_W = 32'd88675123;

   localparam int unsigned SHIFT_A = 11;
   localparam int unsigned SHIFT_B = 19;
   localparam int unsigned SHIFT_C = 8;

   localparam logic [1:0] MODE_RAW   = 2'd0;
   localparam logic [1:0] MODE_MOD   = 2'd1;
   localparam logic [1:0] MODE_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]               mode;
      logic [WORD_W-1:0]        upper;
      logic signed [WORD_W-1:0] lower;
   } xsr_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              zero_bound;
   } xsr_rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } xsr_div_stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/xsr_divider.sv =====
// ----------------------------------------------------------------------------
// xsr_divider
// Restoring divider, one quotient bit per cycle; returns the remainder only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xsr_divider
   import xsr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [WORD_W-1:0] dividend,
   input  wire logic [WORD_W-1:0] divisor,
   output xsr_div_stat_type       stat,
   output logic [WORD_W-1:0]      remainder
);

   logic [WORD_W-1:0]    rem_ff, rem_in;
   logic [WORD_W-1:0]    dvd_ff;
   logic [WORD_W-1:0]    dsr_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [WORD_W:0]      shifted;
   logic [WORD_W:0]      trial;

   // shift in the next dividend bit and subtract when it fits
   always_comb begin
      shifted = {rem_ff, dvd_ff[WORD_W-1]};
      trial   = shifted - {1'b0, dsr_ff};
      if (shifted >= {1'b0, dsr_ff}) begin
         rem_in = trial[WORD_W-1:0];
      end else begin
         rem_in = shifted[WORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            dvd_ff  <= dividend;
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= {dvd_ff[WORD_W-2:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== rtl/core/xorshift128_ranged_random_top.sv =====
// ----------------------------------------------------------------------------
// xorshift128_ranged_random_top
// xorshift128 generator with raw, modulo-bound and signed-range results.
// ----------------------------------------------------------------------------
//  channel | ports                              | carries
//  --------+------------------------------------+------------------------------
//  request | req_valid, req_ready, req_payload  | mode, upper, lower
//  result  | rsp_valid, rsp_ready, rsp_payload  | value, zero_bound
//
//  The generator advances at the edge that accepts a request.
//  Raw word or zero bound: the result goes through the setup and finish states
//  and is registered on leaving finish. Modulo or range: the shared restoring
//  divider works one bit at a time in the divide state, before finish.
//  req_ready is high only in the idle state; a waiting result holds the
//  finish state until rsp_ready. Synchronous reset reloads the seeds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "xorshift128_ranged_random_top_defines.svh"

module xorshift128_ranged_random_top
   import xsr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire xsr_req_type  req_payload,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output xsr_rsp_type       rsp_payload
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type         state_ff;
   logic [WORD_W-1:0] word_x_ff, word_y_ff, word_z_ff, word_w_ff;
   logic [WORD_W-1:0] t_word, word_w_in;
   logic [WORD_W-1:0] divisor_in;
   logic              ranged_in;
   logic [WORD_W-1:0] raw_ff;
   logic [WORD_W-1:0] divisor_ff;
   logic [WORD_W-1:0] offset_ff;
   logic              ranged_ff;
   logic [WORD_W-1:0] value_ff;
   logic              flag_ff;
   logic              rsp_valid_ff;
   xsr_rsp_type       rsp_ff;
   logic              accept;
   logic              div_start;
   xsr_div_stat_type  div_stat;
   logic [WORD_W-1:0] div_rem;

   assign accept = req_valid && req_ready;

   // one generator step
   always_comb begin
      t_word    = word_x_ff ^ (word_x_ff << SHIFT_A);
      word_w_in = word_w_ff ^ (word_w_ff >> SHIFT_B) ^ t_word ^ (t_word >> SHIFT_C);
   end

   always_comb begin
      ranged_in  = 1'b0;
      divisor_in = req_payload.upper;
      unique case (req_payload.mode)
         MODE_MOD: begin
            ranged_in = 1'b1;
         end
         MODE_RANGE: begin
            ranged_in  = 1'b1;
            divisor_in = req_payload.upper - $unsigned(req_payload.lower) + 1'b1;
         end
         default: begin
            ranged_in = 1'b0;
         end
      endcase
   end

   assign div_start = (state_ff == ST_SETUP) && ranged_ff && (divisor_ff != '0);

   xsr_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (raw_ff),
      .divisor   (divisor_ff),
      .stat      (div_stat),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         word_x_ff    <= SEED_X;
         word_y_ff    <= SEED_Y;
         word_z_ff    <= SEED_Z;
         word_w_ff    <= SEED_W;
      end else begin
         // the finish state reloads the result register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  word_x_ff  <= word_y_ff;
                  word_y_ff  <= word_z_ff;
                  word_z_ff  <= word_w_ff;
                  word_w_ff  <= word_w_in;
                  raw_ff     <= word_w_in;
                  divisor_ff <= divisor_in;
                  ranged_ff  <= ranged_in;
                  offset_ff  <= (req_payload.mode == MODE_RANGE) ?
                                $unsigned(req_payload.lower) : '0;
                  state_ff   <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               if (div_start) begin
                  state_ff <= ST_DIVIDE;
               end else begin
                  // raw word, or a zero bound passed through with the flag
                  value_ff <= raw_ff;
                  flag_ff  <= ranged_ff;
                  state_ff <= ST_FINISH;
               end
            end
            ST_DIVIDE: begin
               if (div_stat.done) begin
                  value_ff <= div_rem + offset_ff;
                  flag_ff  <= 1'b0;
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // hold until the result register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.value      <= value_ff;
                  rsp_ff.zero_bound <= flag_ff;
                  rsp_valid_ff      <= 1'b1;
                  state_ff          <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `XSR_ASSERT_NEXT(a_busy_after_accept, accept, !req_ready, "ready high after accept")
   `XSR_ASSERT_IMPLY(a_div_in_divide, div_stat.busy || div_stat.done, state_ff == ST_DIVIDE, "divider active outside divide state")
   `XSR_ASSERT_IMPLY(a_rsp_from_finish, $rose(rsp_valid_ff), $past(state_ff == ST_FINISH), "result raised outside finish")
   `XSR_ASSERT_NEXT(a_start_busy, div_start, div_stat.busy, "divider not busy after start")

endmodule

`default_nettype wire
